@@ hw/rtl/rti_pkg.sv @@
// ----------------------------------------------------------------------------
// rti_pkg
// shared types and constants for the ray / triangle intersection core
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int CW       = 32;
  localparam int FB       = 16;
  localparam int TAG_W    = 32;
  localparam int DIST_W   = 31;
  localparam int NUM_REGS = 6;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

  typedef struct packed {
    logic signed [CW-1:0] vert_a_x;
    logic signed [CW-1:0] vert_a_y;
    logic signed [CW-1:0] vert_a_z;
    logic signed [CW-1:0] vert_b_x;
    logic signed [CW-1:0] vert_b_y;
    logic signed [CW-1:0] vert_b_z;
    logic signed [CW-1:0] vert_c_x;
    logic signed [CW-1:0] vert_c_y;
    logic signed [CW-1:0] vert_c_z;
    logic [TAG_W-1:0]     tri_tag;
  } rti_in_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
    logic [TAG_W-1:0]  tag_out;
  } rti_out_t;

endpackage

@@ hw/rtl/ray_triangle_intersect_core.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core
// Moller-Trumbore ray / triangle test against a ray held in registers
// ----------------------------------------------------------------------------
//  channel  | ports                              | handshake
//  input    | in_start, in_busy, in_item         | taken when start && !busy
//  result   | out_strobe, out_item               | one cycle, no back-pressure
//  config   | cfg_we, cfg_idx, cfg_data          | write when cfg_we high
//
//  one triangle accepted per cycle; busy is always low
//  pipeline: 8 geometry stages, a saturation stage, divider stages of one quotient bit each, output register
//  reset: ray origin 0, direction (0,0,1.0); pipeline emptied
//  the receiver cannot stall, so no stage ever holds
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core import rti_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_start,
  output logic                  in_busy,
  input  rti_in_t               in_item,
  output logic                  out_strobe,
  output rti_out_t              out_item,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_idx,
  input  logic [CW-1:0]         cfg_data
);

  localparam int DW = 4*CW + 8;

  logic [CW-1:0] ox_r, oy_r, oz_r, dx_r, dy_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0; oy_r <= '0; oz_r <= '0;
      dx_r <= '0; dy_r <= '0;
      dz_r <= CW'(1) << FB;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ORIGIN_X: ox_r <= cfg_data;
        REG_ORIGIN_Y: oy_r <= cfg_data;
        REG_ORIGIN_Z: oz_r <= cfg_data;
        REG_DIR_X:    dx_r <= cfg_data;
        REG_DIR_Y:    dy_r <= cfg_data;
        REG_DIR_Z:    dz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_busy = 1'b0;

  logic              cls_vld, cls_go;
  logic [DW-1:0]     cls_tn, cls_det;
  logic [TAG_W-1:0]  cls_tag;

  rti_front #(.W(CW), .DW(DW)) u_front (
    .clk, .rst_n,
    .in_vld (in_start),
    .ox (ox_r), .oy (oy_r), .oz (oz_r), .dx (dx_r), .dy (dy_r), .dz (dz_r),
    .ax (in_item.vert_a_x), .ay (in_item.vert_a_y), .az (in_item.vert_a_z),
    .bx (in_item.vert_b_x), .by (in_item.vert_b_y), .bz (in_item.vert_b_z),
    .cx (in_item.vert_c_x), .cy (in_item.vert_c_y), .cz (in_item.vert_c_z),
    .tag (in_item.tri_tag),
    .cls_vld, .cls_go, .cls_tn, .cls_det, .cls_tag
  );

  rti_back #(.DW(DW), .FBITS(FB)) u_back (
    .clk, .rst_n,
    .cls_vld, .cls_go, .cls_tn, .cls_det, .cls_tag,
    .out_strobe, .out_item
  );

endmodule

@@ hw/rtl/rti_front.sv @@
// ----------------------------------------------------------------------------
// rti_front
// geometry pipeline: edges, cross products, determinant and numerators,
// then sign fold and inside tests; emits a classified item per triangle
// ----------------------------------------------------------------------------
module rti_front import rti_pkg::*; #(
  parameter int W  = 32,
  parameter int DW = 4*W+8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [W-1:0]        ox, oy, oz, dx, dy, dz,
  input  logic [W-1:0]        ax, ay, az, bx, by, bz, cx, cy, cz,
  input  logic [TAG_W-1:0]    tag,
  output logic                cls_vld,
  output logic                cls_go,
  output logic [DW-1:0]       cls_tn,
  output logic [DW-1:0]       cls_det,
  output logic [TAG_W-1:0]    cls_tag
);

  localparam int EW = W + 1;
  localparam int PW = 2*EW + 1;
  localparam int HW = PW - EW;
  localparam int MW = EW + HW;

  // stage 1: differences
  logic s1_vld_r;
  logic signed [EW-1:0] e1_r [3], e2_r [3], s_r [3], d_r [3];
  logic [TAG_W-1:0] s1_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= in_vld;
    e1_r[0] <= $signed({bx[W-1], bx}) - $signed({ax[W-1], ax});
    e1_r[1] <= $signed({by[W-1], by}) - $signed({ay[W-1], ay});
    e1_r[2] <= $signed({bz[W-1], bz}) - $signed({az[W-1], az});
    e2_r[0] <= $signed({cx[W-1], cx}) - $signed({ax[W-1], ax});
    e2_r[1] <= $signed({cy[W-1], cy}) - $signed({ay[W-1], ay});
    e2_r[2] <= $signed({cz[W-1], cz}) - $signed({az[W-1], az});
    s_r[0]  <= $signed({ox[W-1], ox}) - $signed({ax[W-1], ax});
    s_r[1]  <= $signed({oy[W-1], oy}) - $signed({ay[W-1], ay});
    s_r[2]  <= $signed({oz[W-1], oz}) - $signed({az[W-1], az});
    d_r[0]  <= $signed({dx[W-1], dx});
    d_r[1]  <= $signed({dy[W-1], dy});
    d_r[2]  <= $signed({dz[W-1], dz});
    s1_tag_r <= tag;
  end

  // stage 2: cross product terms
  logic s2_vld_r;
  logic signed [PW-1:0] pm_r [6], qm_r [6];
  logic signed [EW-1:0] e1b_r [3], e2b_r [3], sb_r [3], db_r [3];
  logic [TAG_W-1:0] s2_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    pm_r[0] <= PW'(d_r[1] * e2_r[2]);
    pm_r[1] <= PW'(d_r[2] * e2_r[1]);
    pm_r[2] <= PW'(d_r[2] * e2_r[0]);
    pm_r[3] <= PW'(d_r[0] * e2_r[2]);
    pm_r[4] <= PW'(d_r[0] * e2_r[1]);
    pm_r[5] <= PW'(d_r[1] * e2_r[0]);
    qm_r[0] <= PW'(s_r[1] * e1_r[2]);
    qm_r[1] <= PW'(s_r[2] * e1_r[1]);
    qm_r[2] <= PW'(s_r[2] * e1_r[0]);
    qm_r[3] <= PW'(s_r[0] * e1_r[2]);
    qm_r[4] <= PW'(s_r[0] * e1_r[1]);
    qm_r[5] <= PW'(s_r[1] * e1_r[0]);
    e1b_r <= e1_r; e2b_r <= e2_r; sb_r <= s_r; db_r <= d_r;
    s2_tag_r <= s1_tag_r;
  end

  // stage 3: cross products
  logic s3_vld_r;
  logic signed [PW-1:0] p_r [3], q_r [3];
  logic signed [EW-1:0] e1c_r [3], e2c_r [3], sc_r [3], dc_r [3];
  logic [TAG_W-1:0] s3_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
    p_r[0] <= pm_r[0] - pm_r[1];
    p_r[1] <= pm_r[2] - pm_r[3];
    p_r[2] <= pm_r[4] - pm_r[5];
    q_r[0] <= qm_r[0] - qm_r[1];
    q_r[1] <= qm_r[2] - qm_r[3];
    q_r[2] <= qm_r[4] - qm_r[5];
    e1c_r <= e1b_r; e2c_r <= e2b_r; sc_r <= sb_r; dc_r <= db_r;
    s3_tag_r <= s2_tag_r;
  end

  // stage 4a: dot product partial terms, p and q split into high and low halves
  logic s4a_vld_r;
  logic signed [MW-1:0] dl_r [3], dh_r [3], ul_r [3], uh_r [3];
  logic signed [MW-1:0] vl_r [3], vh_r [3], tl_r [3], th_r [3];
  logic [TAG_W-1:0] s4a_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4a_vld_r <= 1'b0;
    else        s4a_vld_r <= s3_vld_r;
    for (int i = 0; i < 3; i++) begin
      dl_r[i] <= MW'(e1c_r[i] * $signed({1'b0, p_r[i][EW-1:0]}));
      dh_r[i] <= MW'(e1c_r[i] * $signed(p_r[i][PW-1:EW]));
      ul_r[i] <= MW'(sc_r[i] * $signed({1'b0, p_r[i][EW-1:0]}));
      uh_r[i] <= MW'(sc_r[i] * $signed(p_r[i][PW-1:EW]));
      vl_r[i] <= MW'(dc_r[i] * $signed({1'b0, q_r[i][EW-1:0]}));
      vh_r[i] <= MW'(dc_r[i] * $signed(q_r[i][PW-1:EW]));
      tl_r[i] <= MW'(e2c_r[i] * $signed({1'b0, q_r[i][EW-1:0]}));
      th_r[i] <= MW'(e2c_r[i] * $signed(q_r[i][PW-1:EW]));
    end
    s4a_tag_r <= s3_tag_r;
  end

  // stage 4b: dot product terms
  logic s4_vld_r;
  logic signed [DW-1:0] dm_r [3], um_r [3], vm_r [3], tm_r [3];
  logic [TAG_W-1:0] s4_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= s4a_vld_r;
    for (int i = 0; i < 3; i++) begin
      dm_r[i] <= (DW'(dh_r[i]) <<< EW) + DW'(dl_r[i]);
      um_r[i] <= (DW'(uh_r[i]) <<< EW) + DW'(ul_r[i]);
      vm_r[i] <= (DW'(vh_r[i]) <<< EW) + DW'(vl_r[i]);
      tm_r[i] <= (DW'(th_r[i]) <<< EW) + DW'(tl_r[i]);
    end
    s4_tag_r <= s4a_tag_r;
  end

  // stage 5: sums
  logic s5_vld_r;
  logic signed [DW-1:0] det_r, un_r, vn_r, tn_r;
  logic [TAG_W-1:0] s5_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else        s5_vld_r <= s4_vld_r;
    det_r <= dm_r[0] + dm_r[1] + dm_r[2];
    un_r  <= um_r[0] + um_r[1] + um_r[2];
    vn_r  <= vm_r[0] + vm_r[1] + vm_r[2];
    tn_r  <= tm_r[0] + tm_r[1] + tm_r[2];
    s5_tag_r <= s4_tag_r;
  end

  // stage 6: sign fold
  logic s6_vld_r, s6_zero_r;
  logic signed [DW-1:0] det6_r, un6_r, vn6_r, tn6_r;
  logic [TAG_W-1:0] s6_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else        s6_vld_r <= s5_vld_r;
    s6_zero_r <= (det_r == '0);
    if (det_r[DW-1]) begin
      det6_r <= -det_r; un6_r <= -un_r; vn6_r <= -vn_r; tn6_r <= -tn_r;
    end else begin
      det6_r <= det_r; un6_r <= un_r; vn6_r <= vn_r; tn6_r <= tn_r;
    end
    s6_tag_r <= s5_tag_r;
  end

  // stage 7: range tests
  logic signed [DW-1:0] uv;
  logic go_nxt;
  assign uv = un6_r + vn6_r;
  assign go_nxt = !s6_zero_r && !un6_r[DW-1] && !(un6_r > det6_r) && !vn6_r[DW-1]
                  && !(uv > det6_r) && !tn6_r[DW-1] && (tn6_r != '0);

  logic s7_vld_r, s7_go_r;
  logic [DW-1:0] s7_tn_r, s7_det_r;
  logic [TAG_W-1:0] s7_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_vld_r <= 1'b0;
    else        s7_vld_r <= s6_vld_r;
    s7_go_r  <= go_nxt;
    s7_tn_r  <= tn6_r;
    s7_det_r <= det6_r;
    s7_tag_r <= s6_tag_r;
  end

  assign cls_vld = s7_vld_r;
  assign cls_go  = s7_go_r;
  assign cls_tn  = s7_tn_r;
  assign cls_det = s7_det_r;
  assign cls_tag = s7_tag_r;

endmodule

@@ hw/rtl/rti_back.sv @@
// ----------------------------------------------------------------------------
// rti_back
// pipelined restoring divider for t, one quotient bit per stage,
// with saturation and miss masking
// ----------------------------------------------------------------------------
module rti_back import rti_pkg::*; #(
  parameter int DW = 136,
  parameter int FBITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cls_vld,
  input  logic              cls_go,
  input  logic [DW-1:0]     cls_tn,
  input  logic [DW-1:0]     cls_det,
  input  logic [TAG_W-1:0]  cls_tag,
  output logic              out_strobe,
  output rti_out_t          out_item
);

  // quotient bits at or above DIST_W only matter as saturation; tn < 2^(DW-1)
  localparam int QB = DIST_W + 1;
  localparam int NW = DW + FBITS;
  localparam int HI = NW - QB;

  logic [NW-1:0] nsh;
  assign nsh = {cls_tn, {FBITS{1'b0}}};

  // stage 0: high quotient bits nonzero iff (tn<<F) >> QB >= det
  // then QB division stages; remainder starts as the high part, which is < det unless saturated
  logic              v_r   [QB+1];
  logic              go_r  [QB+1];
  logic              sat_r [QB+1];
  logic [DW:0]       rem_r [QB+1];
  logic [QB-1:0]     nlo_r [QB+1];
  logic [QB-1:0]     q_r   [QB+1];
  logic [DW-1:0]     dv_r  [QB+1];
  logic [TAG_W-1:0]  tg_r  [QB+1];

  always_ff @(posedge clk) begin
    logic [DW+1:0] trial;
    logic          ge;
    if (!rst_n) begin
      for (int k = 0; k <= QB; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[0] <= cls_vld;
      for (int k = 0; k < QB; k++) v_r[k+1] <= v_r[k];
    end
    go_r[0]  <= cls_go;
    sat_r[0] <= ({{(DW-HI){1'b0}}, nsh[NW-1:QB]} >= cls_det);
    rem_r[0] <= (DW+1)'(nsh[NW-1:QB]);
    nlo_r[0] <= nsh[QB-1:0];
    q_r[0]   <= '0;
    dv_r[0]  <= cls_det;
    tg_r[0]  <= cls_tag;
    for (int k = 0; k < QB; k++) begin
      trial = {rem_r[k], nlo_r[k][QB-1]};
      ge    = (trial >= {2'b00, dv_r[k]});
      go_r[k+1]  <= go_r[k];
      sat_r[k+1] <= sat_r[k];
      rem_r[k+1] <= ge ? (DW+1)'(trial - {2'b00, dv_r[k]}) : trial[DW:0];
      nlo_r[k+1] <= {nlo_r[k][QB-2:0], 1'b0};
      q_r[k+1]   <= {q_r[k][QB-2:0], ge};
      dv_r[k+1]  <= dv_r[k];
      tg_r[k+1]  <= tg_r[k];
    end
  end

  logic [QB-1:0] qf;
  logic          sat, ok;
  assign qf  = q_r[QB];
  assign sat = sat_r[QB] || qf[QB-1];
  assign ok  = go_r[QB] && (sat || (qf != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= v_r[QB];
    out_item.hit      <= ok;
    out_item.distance <= !ok ? '0 : (sat ? {DIST_W{1'b1}} : qf[DIST_W-1:0]);
    out_item.tag_out  <= tg_r[QB];
  end

endmodule

@@ tb/ray_triangle_checker.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_checker
// tracks the ray registers, predicts each triangle's hit and distance with
// exact wide arithmetic, and compares every result strobe in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_triangle_checker import rti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_start,
  input  logic                 in_busy,
  input  rti_in_t              in_item,
  input  logic                 out_strobe,
  input  rti_out_t             out_item,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_idx,
  input  logic [CW-1:0]        cfg_data,
  output int                   fail_count,
  output int                   pending
);

  typedef logic signed [255:0] wide_t;

  logic [CW-1:0] ray_org [3];
  logic [CW-1:0] ray_dir [3];
  rti_out_t      expected_hits [$];

  function automatic wide_t ext(logic [CW-1:0] v);
    return {{(256-CW){v[CW-1]}}, v};
  endfunction

  function automatic rti_out_t predict_hit(rti_in_t t);
    wide_t a [3], b [3], c [3], o [3], d [3];
    wide_t e1 [3], e2 [3], s [3], p [3], q [3];
    wide_t det, un, vn, tn, quo;
    rti_out_t r;
    a[0] = ext(t.vert_a_x); a[1] = ext(t.vert_a_y); a[2] = ext(t.vert_a_z);
    b[0] = ext(t.vert_b_x); b[1] = ext(t.vert_b_y); b[2] = ext(t.vert_b_z);
    c[0] = ext(t.vert_c_x); c[1] = ext(t.vert_c_y); c[2] = ext(t.vert_c_z);
    for (int i = 0; i < 3; i++) begin
      o[i]  = ext(ray_org[i]);
      d[i]  = ext(ray_dir[i]);
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      s[i]  = o[i] - a[i];
    end
    p[0] = d[1] * e2[2] - d[2] * e2[1];
    p[1] = d[2] * e2[0] - d[0] * e2[2];
    p[2] = d[0] * e2[1] - d[1] * e2[0];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    un  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
    vn  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    tn  = q[0] * e2[0] + q[1] * e2[1] + q[2] * e2[2];
    r = '0;
    r.tag_out = t.tri_tag;
    if (det == 0) return r;
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    if (un < 0 || un > det || vn < 0 || un + vn > det || tn <= 0) return r;
    quo = (tn <<< FB) / det;
    if (quo == 0) return r;
    r.hit = 1'b1;
    r.distance = (quo > wide_t'(32'h7FFF_FFFF)) ? '1 : quo[DIST_W-1:0];
    return r;
  endfunction

  assign pending = expected_hits.size();

  always @(posedge clk) begin
    rti_out_t exp_r;
    if (!rst_n) begin
      ray_org[0] <= '0; ray_org[1] <= '0; ray_org[2] <= '0;
      ray_dir[0] <= '0; ray_dir[1] <= '0; ray_dir[2] <= CW'(1) << FB;
      expected_hits.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_ORIGIN_X: ray_org[0] <= cfg_data;
          REG_ORIGIN_Y: ray_org[1] <= cfg_data;
          REG_ORIGIN_Z: ray_org[2] <= cfg_data;
          REG_DIR_X:    ray_dir[0] <= cfg_data;
          REG_DIR_Y:    ray_dir[1] <= cfg_data;
          REG_DIR_Z:    ray_dir[2] <= cfg_data;
          default: ;
        endcase
      end
      if (in_start && !in_busy) expected_hits.push_back(predict_hit(in_item));
      if (out_strobe) begin
        if (expected_hits.size() == 0) begin
          $error("result with nothing expected: tag %h", out_item.tag_out);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_hits.pop_front();
          if (out_item.hit !== exp_r.hit)
            $error("hit expected %0d actual %0d", exp_r.hit, out_item.hit);
          if (out_item.distance !== exp_r.distance)
            $error("distance expected %h actual %h", exp_r.distance, out_item.distance);
          if (out_item.tag_out !== exp_r.tag_out)
            $error("tag_out expected %h actual %h", exp_r.tag_out, out_item.tag_out);
          if (out_item !== exp_r) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

@@ tb/tb_ray_triangle_intersect_core.sv @@
// ----------------------------------------------------------------------------
// tb_ray_triangle_intersect_core
// streams directed and random triangles against several ray settings with
// random sender gaps; the checker predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ray_triangle_intersect_core;
  import rti_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam logic [CW-1:0] ONE = CW'(1) << FB;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_start = 1'b0;
  logic                 in_busy;
  rti_in_t              in_item = '0;
  logic                 out_strobe;
  rti_out_t             out_item;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx = '0;
  logic [CW-1:0]        cfg_data = '0;
  int                   fail_count;
  int                   pending;
  int                   idle_pct = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ray_triangle_intersect_core dut (.*);

  ray_triangle_checker chk (.*);

  initial begin
    #4ms;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_ray(logic [CW-1:0] ox, oy, oz, dx, dy, dz);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
  endtask

  task automatic drain;
    in_start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // item stays offered until a cycle with busy low
  task automatic send_tri(rti_in_t t);
    logic b;
    while ($urandom_range(99) < idle_pct) begin
      in_start <= 1'b0;
      @(posedge clk);
    end
    in_start <= 1'b1;
    in_item  <= t;
    do begin
      @(negedge clk);
      b = in_busy;
      @(posedge clk);
    end while (b);
  endtask

  function automatic logic [CW-1:0] near(int span);
    return CW'($urandom_range(0, 2 * span)) - CW'(span);
  endfunction

  function automatic rti_in_t rand_tri(int kind);
    rti_in_t t;
    int span;
    t = rti_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom});
    if (kind < 75) begin
      span = (kind < 40) ? (4 << FB) : (kind < 65) ? (256 << FB) : 16;
      t.vert_a_x = near(span); t.vert_a_y = near(span); t.vert_a_z = near(span);
      t.vert_b_x = near(span); t.vert_b_y = near(span); t.vert_b_z = near(span);
      t.vert_c_x = near(span); t.vert_c_y = near(span); t.vert_c_z = near(span);
    end else if (kind < 82) begin
      t.vert_b_x = t.vert_a_x; t.vert_b_y = t.vert_a_y; t.vert_b_z = t.vert_a_z;
    end
    return t;
  endfunction

  function automatic rti_in_t make_tri(logic [CW-1:0] ax, ay, az, bx, by, bz,
                                       cx, cy, cz, logic [TAG_W-1:0] tag);
    return '{ax, ay, az, bx, by, bz, cx, cy, cz, tag};
  endfunction

  initial begin
    logic [CW-1:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7FFF_FFFF;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // default ray from origin along +z
    send_tri(make_tri(-ONE, -ONE, ONE, 2*ONE, -ONE, ONE, -ONE, 2*ONE, ONE, 32'h1));
    send_tri(make_tri(-ONE, -ONE, -ONE, 2*ONE, -ONE, -ONE, -ONE, 2*ONE, -ONE, 32'h2));
    send_tri(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 32'h3));
    send_tri(make_tri(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE, 32'h4));
    send_tri(make_tri(ONE, 0, ONE, 0, 0, ONE, 0, ONE, ONE, 32'h5));
    send_tri(make_tri(ONE, ONE, ONE, 2*ONE, ONE, ONE, ONE, 2*ONE, ONE, 32'h6));
    send_tri(make_tri(0, 0, 0, 0, ONE, 0, 0, 0, ONE, 32'h7));
    send_tri(make_tri(-ONE, -ONE, 1, 2*ONE, -ONE, 1, -ONE, 2*ONE, 1, 32'h8));
    send_tri(make_tri(-ONE, -ONE, mx, mx, -ONE, mx, -ONE, mx, mx, 32'h9));
    send_tri(make_tri(mn, mn, ONE, mx, mn, ONE, mn, mx, ONE, 32'hA));
    send_tri(make_tri(mn, mn, mx, mx, mn, mx, mn, mx, mx, 32'hFFFF_FFFF));
    send_tri(make_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn, 32'h0));
    send_tri(make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx, 32'hB));
    send_tri(make_tri(mn, mx, mn, mx, mn, mx, mn, mx, mn, 32'hC));
    send_tri(make_tri(-1, -1, 1, 1, -1, 1, -1, 1, 1, 32'hD));
    drain();
    set_ray(mx, mn, 0, 1, 1, 1);
    send_tri(make_tri(mn, mn, mx, mx, mn, mx, mn, mx, mx, 32'hE));
    send_tri(make_tri(mx, mn, mn, mx, mx, mn, mx, mn, mx, 32'hF));
    drain();
    set_ray(0, 0, 0, 0, 0, 0);
    send_tri(make_tri(-ONE, -ONE, ONE, 2*ONE, -ONE, ONE, -ONE, 2*ONE, ONE, 32'h10));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_ray(0, 0, 0, 0, 0, ONE);
        1: set_ray(near(ONE), near(ONE), near(ONE), near(ONE), near(ONE), near(ONE));
        2: set_ray(mn, mx, mn, mx, mn, mx);
        3: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        4: set_ray(near(ONE), 0, near(ONE), 1, near(ONE), 1);
        default: set_ray(0, 0, near(4 << FB), near(ONE), near(ONE), ONE);
      endcase
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 87 : 34;
      for (int n = 0; n < 230; n++) send_tri(rand_tri($urandom_range(99)));
      drain();
    end

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
